// ===== rtl/round_robin_task_table_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the round-robin task table
// ---------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TASK_TABLE_UNIT_DEFINES_SVH
`define ROUND_ROBIN_TASK_TABLE_UNIT_DEFINES_SVH

// Check a property on every edge outside reset.
`define RRTT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define RRTT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rrtt_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrtt_pkg
// Types and constants shared by the round-robin task table.
// ---------------------------------------------------------------------------
package rrtt_pkg;

    localparam int DATA_W = 32;
    localparam int SLOT_W = 4;

    typedef enum logic {
        KIND_CREATE   = 1'b0,
        KIND_SCHEDULE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    // Decision made by the slot scheduler for one word
    typedef struct packed {
        t_status status;
        logic    wr_new;   // store both pointers into the free slot
        logic    wr_cur;   // save context into the current slot
        logic    rd_sel;   // read the selected slot
        logic    fwd;      // selected slot is the one being saved
    } t_sched_dec;

endpackage

// ===== rtl/rrtt_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrtt_in_if / rrtt_out_if
// Valid/ready channels for task commands and their results.
// ---------------------------------------------------------------------------
interface rrtt_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [rrtt_pkg::DATA_W-1:0] context_ptr;
    logic [rrtt_pkg::DATA_W-1:0] kernel_stack;

    modport source (output valid, kind, context_ptr, kernel_stack, input ready);
    modport sink   (input valid, kind, context_ptr, kernel_stack, output ready);
endinterface

interface rrtt_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [rrtt_pkg::SLOT_W-1:0] slot;
    logic [rrtt_pkg::DATA_W-1:0] context_out;
    logic [rrtt_pkg::DATA_W-1:0] kernel_stack_out;

    modport source (output valid, status, slot, context_out, kernel_stack_out, input ready);
    modport sink   (input valid, status, slot, context_out, kernel_stack_out, output ready);
endinterface

// ===== rtl/rrtt_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrtt_ram
// Simple dual-port synchronous RAM, registered read, read-before-write.
// ---------------------------------------------------------------------------
module rrtt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rrtt_sched.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrtt_sched
// Slot bookkeeping: used marks, current slot, free-slot and round-robin search.
// ---------------------------------------------------------------------------
module rrtt_sched #(
    parameter int SLOTS = 16,
    parameter int IDX_W = $clog2(SLOTS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  rrtt_pkg::t_kind      i_kind,
    output rrtt_pkg::t_sched_dec o_dec,
    output logic [IDX_W-1:0]     o_free_idx,
    output logic [IDX_W-1:0]     o_cur_idx,
    output logic [IDX_W-1:0]     o_sel_idx
);

    logic [SLOTS-1:0] r_used;
    logic [SLOTS-1:0] n_used;
    logic [IDX_W-1:0] r_cur;
    logic [IDX_W-1:0] n_cur;
    logic             r_first;
    logic             n_first;

    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] start_idx;
    logic             hi_found;
    logic [IDX_W-1:0] hi_idx;
    logic             lo_found;
    logic [IDX_W-1:0] lo_idx;
    logic [IDX_W-1:0] sel_idx;

    // Lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Next used slot at or after start_idx, else wrap to the lowest used slot
    always_comb begin
        if (r_first) begin
            start_idx = r_cur;
        end else if (r_cur == IDX_W'(SLOTS - 1)) begin
            start_idx = '0;
        end else begin
            start_idx = r_cur + 1'b1;
        end
        hi_found = 1'b0;
        hi_idx   = '0;
        lo_found = 1'b0;
        lo_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_used[i]) begin
                lo_found = 1'b1;
                lo_idx   = IDX_W'(i);
                if (IDX_W'(i) >= start_idx) begin
                    hi_found = 1'b1;
                    hi_idx   = IDX_W'(i);
                end
            end
        end
        sel_idx = hi_found ? hi_idx : lo_idx;
    end

    always_comb begin
        o_dec   = '{status: rrtt_pkg::ST_OK, default: 1'b0};
        n_used  = r_used;
        n_cur   = r_cur;
        n_first = r_first;
        unique case (i_kind)
            rrtt_pkg::KIND_CREATE: begin
                o_dec.status = free_found ? rrtt_pkg::ST_OK : rrtt_pkg::ST_FULL;
                o_dec.wr_new = free_found;
                if (i_go && free_found) begin
                    n_used[free_idx] = 1'b1;
                end
            end
            rrtt_pkg::KIND_SCHEDULE: begin
                o_dec.status = lo_found ? rrtt_pkg::ST_OK : rrtt_pkg::ST_EMPTY;
                o_dec.rd_sel = lo_found;
                o_dec.wr_cur = lo_found && !r_first;
                o_dec.fwd    = lo_found && !r_first && (sel_idx == r_cur);
                if (i_go && lo_found) begin
                    n_cur   = sel_idx;
                    n_first = 1'b0;
                end
            end
            default: begin
                o_dec.status = rrtt_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_cur   <= '0;
            r_first <= 1'b1;
        end else begin
            r_used  <= n_used;
            r_cur   <= n_cur;
            r_first <= n_first;
        end
    end

    assign o_free_idx = free_idx;
    assign o_cur_idx  = r_cur;
    assign o_sel_idx  = sel_idx;

endmodule

// ===== rtl/round_robin_task_table_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// round_robin_task_table_unit
// Task table with lowest-free-slot create and round-robin context switch.
// ---------------------------------------------------------------------------
// In the accept cycle the slot search runs over the used marks, the slot
// memories are written and the selected slot is read. In the read state,
// once the result register is free, the registered read data of the context
// and kernel stack memories is loaded into the result register. The input is
// ready again once the result register has taken the word, so a stalled
// output adds its stall cycles to the next word. A result on create echoes
// the stored pointers; a failed create or schedule returns zero slot and
// pointers. A context saved and selected by the same tick is forwarded. No
// clearing pass is needed after reset.
module round_robin_task_table_unit #(
    parameter int SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rrtt_in_if.sink           i_in,
    rrtt_out_if.source        o_out
);

    localparam int IDX_W = $clog2(SLOTS);

    rrtt_pkg::t_state     r_state;
    rrtt_pkg::t_state     n_state;
    rrtt_pkg::t_sched_dec dec;
    rrtt_pkg::t_kind      in_kind;

    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] cur_idx;
    logic [IDX_W-1:0] sel_idx;
    logic             in_accept;
    logic             out_free;
    logic             out_load;

    logic                        ctx_we;
    logic [IDX_W-1:0]            ctx_waddr;
    logic [rrtt_pkg::DATA_W-1:0] ctx_rdata;
    logic [rrtt_pkg::DATA_W-1:0] ks_rdata;

    rrtt_pkg::t_status           r_status;
    rrtt_pkg::t_kind             r_kind;
    logic                        r_fwd;
    logic [IDX_W-1:0]            r_slot;
    logic [rrtt_pkg::DATA_W-1:0] r_ctx;
    logic [rrtt_pkg::DATA_W-1:0] r_ks;

    logic                        r_out_valid;
    rrtt_pkg::t_status           r_out_status;
    logic [rrtt_pkg::SLOT_W-1:0] r_out_slot;
    logic [rrtt_pkg::DATA_W-1:0] r_out_ctx;
    logic [rrtt_pkg::DATA_W-1:0] r_out_ks;
    logic [IDX_W+rrtt_pkg::SLOT_W-1:0] slot_ext;

    assign in_kind   = rrtt_pkg::t_kind'(i_in.kind);
    assign in_accept = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;

    rrtt_sched #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_sched (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (in_accept),
        .i_kind     (in_kind),
        .o_dec      (dec),
        .o_free_idx (free_idx),
        .o_cur_idx  (cur_idx),
        .o_sel_idx  (sel_idx)
    );

    assign ctx_we    = in_accept && (dec.wr_new || dec.wr_cur);
    assign ctx_waddr = dec.wr_new ? free_idx : cur_idx;

    rrtt_ram #(
        .DEPTH (SLOTS),
        .WIDTH (rrtt_pkg::DATA_W),
        .AW    (IDX_W)
    ) u_ctx_ram (
        .i_clk   (i_clk),
        .i_we    (ctx_we),
        .i_waddr (ctx_waddr),
        .i_wdata (i_in.context_ptr),
        .i_re    (in_accept && dec.rd_sel),
        .i_raddr (sel_idx),
        .o_rdata (ctx_rdata)
    );

    rrtt_ram #(
        .DEPTH (SLOTS),
        .WIDTH (rrtt_pkg::DATA_W),
        .AW    (IDX_W)
    ) u_ks_ram (
        .i_clk   (i_clk),
        .i_we    (in_accept && dec.wr_new),
        .i_waddr (free_idx),
        .i_wdata (i_in.kernel_stack),
        .i_re    (in_accept && dec.rd_sel),
        .i_raddr (sel_idx),
        .o_rdata (ks_rdata)
    );

    // Sequencer
    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            rrtt_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_state = rrtt_pkg::S_READ;
                end
            end
            rrtt_pkg::S_READ: begin
                out_load = out_free;
                if (out_free) begin
                    n_state = rrtt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrtt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrtt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the decision and the incoming pointers for the result cycle
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_status <= dec.status;
            r_kind   <= in_kind;
            r_fwd    <= dec.fwd;
            r_slot   <= (in_kind == rrtt_pkg::KIND_CREATE) ? free_idx : sel_idx;
            r_ctx    <= i_in.context_ptr;
            r_ks     <= i_in.kernel_stack;
        end
    end

    assign slot_ext = {{rrtt_pkg::SLOT_W{1'b0}}, r_slot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_status;
            priority if (r_status != rrtt_pkg::ST_OK) begin
                r_out_slot <= '0;
                r_out_ctx  <= '0;
                r_out_ks   <= '0;
            end else if (r_kind == rrtt_pkg::KIND_CREATE) begin
                r_out_slot <= slot_ext[rrtt_pkg::SLOT_W-1:0];
                r_out_ctx  <= r_ctx;
                r_out_ks   <= r_ks;
            end else begin
                r_out_slot <= slot_ext[rrtt_pkg::SLOT_W-1:0];
                r_out_ctx  <= r_fwd ? r_ctx : ctx_rdata;
                r_out_ks   <= ks_rdata;
            end
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_out_status;
    assign o_out.slot             = r_out_slot;
    assign o_out.context_out      = r_out_ctx;
    assign o_out.kernel_stack_out = r_out_ks;

endmodule

// ===== rtl/rrtt_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrtt_checker
// Port-level checks for the round-robin task table, bound to the top level.
// ---------------------------------------------------------------------------
`include "round_robin_task_table_unit_defines.svh"

module rrtt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [1:0]                  i_out_status,
    input logic [rrtt_pkg::SLOT_W-1:0] i_out_slot,
    input logic [rrtt_pkg::DATA_W-1:0] i_out_ctx,
    input logic [rrtt_pkg::DATA_W-1:0] i_out_ks
);

    `RRTT_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result word dropped while stalled")
    `RRTT_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready, "word accepted while previous word in flight")
    `RRTT_ASSERT(a_fail_zero, i_clk, i_rst_n, i_out_valid && (i_out_status != rrtt_pkg::ST_OK) |-> (i_out_slot == '0) && (i_out_ctx == '0) && (i_out_ks == '0), "failed word carries nonzero payload")
    `RRTT_ASSERT(a_status_code, i_clk, i_rst_n, i_out_valid |-> i_out_status <= rrtt_pkg::ST_EMPTY, "undefined status code")
    `RRTT_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind round_robin_task_table_unit rrtt_checker u_rrtt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_slot   (o_out.slot),
    .i_out_ctx    (o_out.context_out),
    .i_out_ks     (o_out.kernel_stack_out)
);

// ===== bench/rrtt_result_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrtt_result_checker
// Watches the command and result channels of the task table, keeps its own
// copy of the slot table and compares every result word with the one that
// the table should have produced.
// ---------------------------------------------------------------------------
module rrtt_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rrtt_in_if   i_cmd,
    rrtt_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results
);

    localparam int SLOTS = 16;

    typedef struct packed {
        rrtt_pkg::t_status                 status;
        logic [rrtt_pkg::SLOT_W-1:0] slot;
        logic [rrtt_pkg::DATA_W-1:0] context_ptr;
        logic [rrtt_pkg::DATA_W-1:0] kernel_stack;
    } t_task_result;

    logic [rrtt_pkg::DATA_W-1:0] ctx_mem    [SLOTS];
    logic [rrtt_pkg::DATA_W-1:0] kstack_mem [SLOTS];
    bit                          used_mark  [SLOTS];
    logic [rrtt_pkg::SLOT_W-1:0] run_slot;
    bit                          first_tick;
    t_task_result                awaited_results [$];
    int                          mismatches = 0;
    int                          results_seen = 0;

    // Advance the table copy by one command word and return its result.
    function automatic t_task_result table_step(input rrtt_pkg::t_kind kind,
                                                input logic [rrtt_pkg::DATA_W-1:0] ctx,
                                                input logic [rrtt_pkg::DATA_W-1:0] ks);
        t_task_result                r;
        logic [rrtt_pkg::SLOT_W-1:0] cand;
        bit                          found;
        r = '0;
        found = 1'b0;
        if (kind == rrtt_pkg::KIND_CREATE) begin
            r.status = rrtt_pkg::ST_FULL;
            for (int i = 0; i < SLOTS; i++) begin
                if (!found && !used_mark[i]) begin
                    found = 1'b1;
                    used_mark[i] = 1'b1;
                    ctx_mem[i] = ctx;
                    kstack_mem[i] = ks;
                    r.status = rrtt_pkg::ST_OK;
                    r.slot = rrtt_pkg::SLOT_W'(i);
                    r.context_ptr = ctx;
                    r.kernel_stack = ks;
                end
            end
        end else begin
            r.status = rrtt_pkg::ST_EMPTY;
            // The first tick searches from the current slot itself; later ones
            // start one past it. The 4-bit index wraps at the table size.
            cand = first_tick ? run_slot : run_slot + 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!found) begin
                    if (used_mark[cand]) begin
                        found = 1'b1;
                    end else begin
                        cand = cand + 1'b1;
                    end
                end
            end
            if (found) begin
                // Save before reading so a reselected slot returns the new context
                if (!first_tick) begin
                    ctx_mem[run_slot] = ctx;
                end
                run_slot = cand;
                first_tick = 1'b0;
                r.status = rrtt_pkg::ST_OK;
                r.slot = cand;
                r.context_ptr = ctx_mem[cand];
                r.kernel_stack = kstack_mem[cand];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_task_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                used_mark[i] = 1'b0;
            end
            run_slot = '0;
            first_tick = 1'b1;
            awaited_results.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                awaited_results.push_back(table_step(rrtt_pkg::t_kind'(i_cmd.kind),
                                                     i_cmd.context_ptr,
                                                     i_cmd.kernel_stack));
            end
            if (i_res.valid && i_res.ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result word: status=%0d slot=%0d ctx=%h ks=%h",
                                 i_res.status, i_res.slot, i_res.context_out,
                                 i_res.kernel_stack_out);
                    end
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_res.status !== want.status || i_res.slot !== want.slot ||
                        i_res.context_out !== want.context_ptr ||
                        i_res.kernel_stack_out !== want.kernel_stack) begin
                        if (mismatches < 10) begin
                            $display("mismatch on result %0d: expected status=%0d slot=%0d ctx=%h ks=%h",
                                     results_seen, want.status, want.slot,
                                     want.context_ptr, want.kernel_stack);
                            $display("    got status=%0d slot=%0d ctx=%h ks=%h",
                                     i_res.status, i_res.slot, i_res.context_out,
                                     i_res.kernel_stack_out);
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited_results.size();
        o_results    <= results_seen;
    end

endmodule

// ===== bench/round_robin_task_table_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// round_robin_task_table_unit_test
// Drives create and scheduler-tick words into the task table under three
// handshake mixes and one long result stall; the checker beside the block
// predicts each result and the verdict comes from its failure and pending counts.
// ---------------------------------------------------------------------------
module round_robin_task_table_unit_test;

    localparam int RUN_LIMIT = 100000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    int tx_idle_pct = 26;
    int rx_idle_pct = 72;
    bit hold_req = 1'b0;
    int creates_sent = 0;
    int ticks_sent = 0;
    int cycle_count = 0;
    int fail_count;
    int pending_count;
    int result_count;

    rrtt_in_if  cmd_ch ();
    rrtt_out_if res_ch ();

    round_robin_task_table_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    rrtt_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_results    (result_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one word after a random gap and hold it until accepted.
    task automatic offer_command(input rrtt_pkg::t_kind kind,
                                 input logic [rrtt_pkg::DATA_W-1:0] ctx,
                                 input logic [rrtt_pkg::DATA_W-1:0] ks);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.kind         <= kind;
        cmd_ch.context_ptr  <= ctx;
        cmd_ch.kernel_stack <= ks;
        @(posedge i_clk);
        while (!cmd_ch.ready) begin
            @(posedge i_clk);
        end
        if (kind == rrtt_pkg::KIND_CREATE) begin
            creates_sent++;
        end else begin
            ticks_sent++;
        end
    endtask

    task automatic pick_pointer(output logic [rrtt_pkg::DATA_W-1:0] ptr);
        case ($urandom_range(0, 15))
            0:       ptr = '0;
            1:       ptr = '1;
            default: ptr = $urandom;
        endcase
    endtask

    task automatic run_random(input int count, input int create_pct);
        rrtt_pkg::t_kind             kind;
        logic [rrtt_pkg::DATA_W-1:0] ctx;
        logic [rrtt_pkg::DATA_W-1:0] ks;
        for (int n = 0; n < count; n++) begin
            kind = ($urandom_range(0, 99) < create_pct) ? rrtt_pkg::KIND_CREATE
                                                         : rrtt_pkg::KIND_SCHEDULE;
            pick_pointer(ctx);
            pick_pointer(ks);
            offer_command(kind, ctx, ks);
        end
    endtask

    // Result side: random ready, plus one long hold-off when asked.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 299;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        cmd_ch.valid        = 1'b0;
        cmd_ch.kind         = rrtt_pkg::KIND_CREATE;
        cmd_ch.context_ptr  = '0;
        cmd_ch.kernel_stack = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table, before and after the first switch is possible
        offer_command(rrtt_pkg::KIND_SCHEDULE, 32'hffff_ffff, 32'hffff_ffff);
        offer_command(rrtt_pkg::KIND_SCHEDULE, 32'h0000_0000, 32'h0000_0000);
        offer_command(rrtt_pkg::KIND_CREATE, 32'h0000_0000, 32'h0000_0000);
        // First switch picks the current slot without saving
        offer_command(rrtt_pkg::KIND_SCHEDULE, 32'h1234_5678, 32'h0000_0000);
        // Lone used slot: save and reselect it
        offer_command(rrtt_pkg::KIND_SCHEDULE, 32'hffff_ffff, 32'h5555_5555);
        offer_command(rrtt_pkg::KIND_CREATE, 32'hffff_ffff, 32'hffff_ffff);
        offer_command(rrtt_pkg::KIND_CREATE, 32'h0000_0001, 32'h8000_0000);
        offer_command(rrtt_pkg::KIND_SCHEDULE, 32'haaaa_aaaa, 32'h0000_0000);
        offer_command(rrtt_pkg::KIND_SCHEDULE, 32'h5555_5555, 32'hffff_ffff);
        // Wrap back to slot zero
        offer_command(rrtt_pkg::KIND_SCHEDULE, 32'h8000_0000, 32'h0000_0001);
        offer_command(rrtt_pkg::KIND_SCHEDULE, 32'h7fff_ffff, 32'h0000_0000);
        // Kernel task with a zero kernel stack
        offer_command(rrtt_pkg::KIND_CREATE, 32'hdead_0000, 32'h0000_0000);
        offer_command(rrtt_pkg::KIND_CREATE, 32'h5555_5555, 32'haaaa_aaaa);
        offer_command(rrtt_pkg::KIND_SCHEDULE, 32'h0f0f_0f0f, 32'h0000_0000);
        offer_command(rrtt_pkg::KIND_SCHEDULE, 32'hf0f0_f0f0, 32'h0000_0000);
        offer_command(rrtt_pkg::KIND_SCHEDULE, 32'h0000_0000, 32'h0000_0000);
        offer_command(rrtt_pkg::KIND_SCHEDULE, 32'hffff_ffff, 32'h0000_0000);
        offer_command(rrtt_pkg::KIND_SCHEDULE, 32'hc3c3_c3c3, 32'h0000_0000);

        run_random(150, 5);

        tx_idle_pct = 72;
        rx_idle_pct <= 26;
        run_random(150, 5);

        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_req <= 1'b1;
        run_random(150, 5);

        // Fill the table past its end, then keep switching
        for (int n = 0; n < 18; n++) begin
            offer_command(rrtt_pkg::KIND_CREATE, $urandom, $urandom);
        end
        run_random(6, 0);

        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        $display("covered %0d creates and %0d scheduler ticks, %0d result words checked",
                 creates_sent, ticks_sent, result_count);
        $display("table taken from empty to full under three handshake mixes and one long stall");
        if (fail_count == 0 && pending_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
